/* sv/kabf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kabf_pkg
// Shared types, widths and helpers for the angle/bias kalman filter.
// ----------------------------------------------------------------------------
package kabf_pkg;

    localparam int RegW   = 29;
    localparam int FracW  = 28;
    localparam int MulW   = 36;
    localparam int ProdW  = 2 * MulW - FracW;
    localparam int SumW   = 48;
    localparam int DenW   = 33;
    localparam int NumW   = 32 + FracW;

    localparam logic [1:0] RegTimeStep    = 2'd0;
    localparam logic [1:0] RegAngleNoise  = 2'd1;
    localparam logic [1:0] RegBiasNoise   = 2'd2;
    localparam logic [1:0] RegMeasNoise   = 2'd3;

    localparam logic [RegW-1:0] TimeStepRst   = 29'd2684355;
    localparam logic [RegW-1:0] AngleNoiseRst = 29'd268435;
    localparam logic [RegW-1:0] BiasNoiseRst  = 29'd805306;
    localparam logic [RegW-1:0] MeasNoiseRst  = 29'd8053064;

    localparam logic CmdUpdate = 1'b0;
    localparam logic CmdLoad   = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RATE,
        ST_M_ANG,
        ST_M_T,
        ST_T,
        ST_M_P00,
        ST_M_P11,
        ST_DIV0,
        ST_DIV0_W,
        ST_DIV1_W,
        ST_Y,
        ST_M_A,
        ST_M_B,
        ST_M_C0,
        ST_M_C1,
        ST_M_C2,
        ST_M_C3,
        ST_FIN,
        ST_DONE
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [SumW-1:0] x);
        logic signed [SumW-1:0] hi;
        logic signed [SumW-1:0] lo;
        begin
            hi = SumW'(32'sh7fffffff);
            lo = -SumW'(64'sh80000000);
            if (x > hi)
                sat32 = 32'sh7fffffff;
            else if (x < lo)
                sat32 = 32'sh80000000;
            else
                sat32 = x[31:0];
        end
    endfunction

endpackage
`default_nettype wire

/* sv/kalman_angle_bias_filter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter
// Two-state kalman filter (angle, gyro bias) run by a small sequencer
// around one shared multiplier and an iterative gain divider.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// in       input      in_valid/in_stall    cmd, measured_angle, gyro_rate
// out      output     out_valid/out_stall  filtered_angle, unbiased_rate
// cfg      input      cfg_we               cfg_index, cfg_data
//
// an update item spends most of its time in the two 60-step gain divisions (skipped
// when s_sum is not positive); a load item goes straight to the done state.
// one item is worked at a time; in_stall is high while the sequencer runs.
// a finished result waits in the output register while the next item enters.
// reset clears the state estimates, covariance and registers to defaults.
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter
    import kabf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               cmd,
    input  wire logic signed [24:0] measured_angle,
    input  wire logic signed [27:0] gyro_rate,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      filtered_angle,
    output logic signed [31:0]      unbiased_rate,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [RegW-1:0]    cfg_data
);

    state_t state_reg, state_next;

    logic [RegW-1:0] dt_reg, an_reg, bn_reg, mn_reg;

    logic signed [31:0] ang_reg, bias_reg, rate_reg;
    logic signed [31:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] k0_reg, k1_reg;
    logic signed [ProdW-1:0] t_reg;
    logic signed [33:0] y_reg;
    logic signed [24:0] meas_reg;
    logic signed [27:0] gyro_reg;

    logic               out_valid_reg;
    logic signed [31:0] fa_reg, ur_reg;

    logic signed [MulW-1:0]  mul_a, mul_b;
    logic signed [ProdW-1:0] prod;
    logic signed [SumW-1:0]  prod_x;
    logic signed [SumW-1:0]  s_sum;
    logic signed [SumW-1:0]  x_sum;

    logic               div_start, div_done;
    logic signed [31:0] div_num, quot;

    logic accept;
    logic out_free;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign prod_x   = SumW'(prod);
    assign s_sum    = SumW'(p00_reg) + SumW'({1'b0, mn_reg});
    assign x_sum    = SumW'(t_reg) - SumW'(p01_reg) - SumW'(p10_reg)
                      + SumW'({1'b0, an_reg});

    kabf_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // innovation variance holds until the gains are done if cfg leaves mn_reg alone
    kabf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (s_sum[DenW-1:0]),
        .done  (div_done),
        .quot  (quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = (cmd == CmdLoad) ? ST_DONE : ST_RATE;
            end
            ST_RATE:   state_next = ST_M_ANG;
            ST_M_ANG:  state_next = ST_M_T;
            ST_M_T:    state_next = ST_T;
            ST_T:      state_next = ST_M_P00;
            ST_M_P00:  state_next = ST_M_P11;
            ST_M_P11:  state_next = ST_DIV0;
            ST_DIV0:   state_next = (s_sum > 0) ? ST_DIV0_W : ST_Y;
            ST_DIV0_W: if (div_done) state_next = ST_DIV1_W;
            ST_DIV1_W: if (div_done) state_next = ST_Y;
            ST_Y:      state_next = ST_M_A;
            ST_M_A:    state_next = ST_M_B;
            ST_M_B:    state_next = ST_M_C0;
            ST_M_C0:   state_next = ST_M_C1;
            ST_M_C1:   state_next = ST_M_C2;
            ST_M_C2:   state_next = ST_M_C3;
            ST_M_C3:   state_next = ST_FIN;
            ST_FIN:    state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // multiplier operands and divider control
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = p00_reg;
        unique case (state_reg)
            ST_M_ANG:
            begin
                mul_a = MulW'({1'b0, dt_reg});
                mul_b = MulW'(rate_reg);
            end
            ST_M_T:
            begin
                mul_a = MulW'({1'b0, dt_reg});
                mul_b = MulW'(p11_reg);
            end
            ST_M_P00:
            begin
                mul_a = MulW'({1'b0, dt_reg});
                mul_b = x_sum[MulW-1:0];
            end
            ST_M_P11:
            begin
                mul_a = MulW'({1'b0, bn_reg});
                mul_b = MulW'({1'b0, dt_reg});
            end
            ST_DIV0:
            begin
                div_start = (s_sum > 0);
            end
            ST_DIV0_W:
            begin
                div_start = div_done;
                div_num   = p10_reg;
            end
            ST_M_A:
            begin
                mul_a = MulW'(k0_reg);
                mul_b = MulW'(y_reg);
            end
            ST_M_B:
            begin
                mul_a = MulW'(k1_reg);
                mul_b = MulW'(y_reg);
            end
            ST_M_C0:
            begin
                mul_a = MulW'(k1_reg);
                mul_b = MulW'(p00_reg);
            end
            ST_M_C1:
            begin
                mul_a = MulW'(k0_reg);
                mul_b = MulW'(p00_reg);
            end
            ST_M_C2:
            begin
                mul_a = MulW'(k1_reg);
                mul_b = MulW'(p01_reg);
            end
            ST_M_C3:
            begin
                mul_a = MulW'(k0_reg);
                mul_b = MulW'(p01_reg);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dt_reg        <= TimeStepRst;
            an_reg        <= AngleNoiseRst;
            bn_reg        <= BiasNoiseRst;
            mn_reg        <= MeasNoiseRst;
            ang_reg       <= '0;
            bias_reg      <= '0;
            rate_reg      <= '0;
            p00_reg       <= '0;
            p01_reg       <= '0;
            p10_reg       <= '0;
            p11_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    RegTimeStep:   dt_reg <= cfg_data;
                    RegAngleNoise: an_reg <= cfg_data;
                    RegBiasNoise:  bn_reg <= cfg_data;
                    RegMeasNoise:  mn_reg <= cfg_data;
                    default:       dt_reg <= dt_reg;
                endcase
            end

            if ((state_reg == ST_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (cmd == CmdLoad))
                        ang_reg <= 32'(measured_angle);
                end
                ST_RATE:
                    rate_reg <= sat32(SumW'(gyro_reg) - SumW'(bias_reg));
                ST_M_T:
                    ang_reg <= sat32(SumW'(ang_reg) + prod_x);
                ST_M_P11:
                begin
                    p00_reg <= sat32(SumW'(p00_reg) + prod_x);
                    p01_reg <= sat32(SumW'(p01_reg) - SumW'(t_reg));
                    p10_reg <= sat32(SumW'(p10_reg) - SumW'(t_reg));
                end
                ST_DIV0:
                    p11_reg <= sat32(SumW'(p11_reg) + prod_x);
                ST_M_B:
                    ang_reg <= sat32(SumW'(ang_reg) + prod_x);
                ST_M_C0:
                    bias_reg <= sat32(SumW'(bias_reg) + prod_x);
                ST_M_C1:
                    p10_reg <= sat32(SumW'(p10_reg) - prod_x);
                ST_M_C2:
                    p00_reg <= sat32(SumW'(p00_reg) - prod_x);
                ST_M_C3:
                    p11_reg <= sat32(SumW'(p11_reg) - prod_x);
                ST_FIN:
                    p01_reg <= sat32(SumW'(p01_reg) - prod_x);
                default:
                begin
                end
            endcase
        end
    end

    // datapath scratch registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            meas_reg <= measured_angle;
            gyro_reg <= gyro_rate;
        end
        if (state_reg == ST_T)
            t_reg <= prod;
        if (state_reg == ST_DIV0)
        begin
            k0_reg <= '0;
            k1_reg <= '0;
        end
        if ((state_reg == ST_DIV0_W) && div_done)
            k0_reg <= quot;
        if ((state_reg == ST_DIV1_W) && div_done)
            k1_reg <= quot;
        if (state_reg == ST_Y)
            y_reg <= 34'(meas_reg) - 34'(ang_reg);
        if ((state_reg == ST_DONE) && out_free)
        begin
            fa_reg <= ang_reg;
            ur_reg <= rate_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_angle = fa_reg;
    assign unbiased_rate  = ur_reg;

endmodule
`default_nettype wire

/* sv/kabf_mul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kabf_mul
// Shared signed multiplier with q4.28 rescale, round half up, registered.
// ----------------------------------------------------------------------------
module kabf_mul
    import kabf_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic signed [MulW-1:0]  a,
    input  wire logic signed [MulW-1:0]  b,
    output logic signed [ProdW-1:0]      prod
);

    logic signed [2*MulW-1:0] full;
    logic signed [2*MulW-1:0] rounded;
    logic signed [ProdW-1:0]  prod_reg;

    assign full    = a * b;
    assign rounded = full + (2*MulW)'(1 << (FracW - 1));

    // floor shift: upper bits of the two's complement sum
    always_ff @(posedge clk)
    begin
        prod_reg <= rounded[2*MulW-1:FracW];
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

/* sv/kabf_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kabf_div
// Radix-2 restoring divider for the gains: (p * 2^28) / s, toward zero.
// ----------------------------------------------------------------------------
module kabf_div
    import kabf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] num,
    input  wire logic [DenW-1:0]    den,
    output logic                    done,
    output logic signed [31:0]      quot
);

    localparam logic [5:0] LastStep = 6'(NumW - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic [NumW-1:0]   num_reg, num_next;
    logic [DenW-1:0]   den_reg, den_next;
    logic [DenW-1:0]   rem_reg, rem_next;
    logic [DenW:0]     shifted;
    logic [DenW:0]     trial;
    logic [31:0]       mag32;

    assign shifted = {rem_reg, num_reg[NumW-1]};
    assign trial   = shifted - {1'b0, den_reg};
    assign mag32   = 32'(num[31] ? -33'(num) : 33'(num));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (busy_reg)
        begin
            if (trial[DenW])
                rem_next = shifted[DenW-1:0];
            else
                rem_next = trial[DenW-1:0];
            num_next = {num_reg[NumW-2:0], ~trial[DenW]};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == LastStep)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            neg_next  = num[31];
            num_next  = {mag32, {FracW{1'b0}}};
            den_next  = den;
            rem_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    // saturate the signed quotient
    always_comb
    begin
        if (!neg_reg && (num_reg > NumW'(32'h7fffffff)))
            quot = 32'sh7fffffff;
        else if (neg_reg && (num_reg > NumW'(32'h80000000)))
            quot = 32'sh80000000;
        else if (neg_reg)
            quot = -(num_reg[31:0]);
        else
            quot = num_reg[31:0];
    end

    assign done = done_reg;

endmodule
`default_nettype wire
